// ===== rtl/mcc_pkg.sv =====
package mcc_pkg;

   localparam int NOTE_W = 7;
   localparam int VEL_W  = 7;
   localparam int SIZE_W = 4;
   localparam int MAX_W  = 4;
   localparam int REQ_W  = 2;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [MAX_W-1:0]  MAX_NOTES_RESET = 4'd8;
   localparam logic [NOTE_W-1:0] NOTE_TOP        = 7'd127;

   // register index, taken from paddr above the byte offset
   localparam logic [CSR_AW-3:0] REG_MAX_NOTES = 1'b0;

   typedef enum logic [REQ_W-1:0] {
      REQ_START    = 2'd0,
      REQ_NOTE_ON  = 2'd1,
      REQ_NOTE_OFF = 2'd2,
      REQ_UNUSED   = 2'd3
   } req_code_type;

endpackage

// ===== rtl/midi_chord_capture.sv =====
// channel  | direction | beat contents
// req_     | in        | req_type, req_note_number, req_note_velocity
// rsp_     | out       | rsp_chord_note, rsp_chord_size, rsp_last_velocity, rsp_is_last
// csr_     | in/out    | apb-style access to max_notes at byte address 0
//
// one beat at a time: a start or ignored beat is handled in idle; a note on/off adds
// a serial scan through the note store (one read port)
// a completed chord of n notes takes n rounds of a min search through the note store
// reset (synchronous) empties the chord, clears the kept velocity, sets max_notes to 8
// the result register decouples the sides: the last beat may wait while a new
// request is taken; a stalled result only holds up the next chord round

module midi_chord_capture #(
   parameter int CHORD_SLOTS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mcc_pkg::REQ_W-1:0]           req_type,
   input  logic [mcc_pkg::NOTE_W-1:0]          req_note_number,
   input  logic [mcc_pkg::VEL_W-1:0]           req_note_velocity,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mcc_pkg::NOTE_W-1:0]          rsp_chord_note,
   output logic [mcc_pkg::SIZE_W-1:0]          rsp_chord_size,
   output logic [mcc_pkg::VEL_W-1:0]           rsp_last_velocity,
   output logic                                rsp_is_last,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mcc_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [mcc_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [mcc_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                csr_pready
);
   import mcc_pkg::*;

   // count reaches the number of slots, address covers them
   localparam int CW = $clog2(CHORD_SLOTS + 1);
   localparam int AW = (CHORD_SLOTS > 1) ? $clog2(CHORD_SLOTS) : 1;
   localparam int LW = (CW > MAX_W) ? CW : MAX_W;

   typedef enum logic [1:0] {
      ST_IDLE,   // waiting for a request beat
      ST_MATCH,  // serial search of the store for the request note
      ST_MIN,    // serial search for the next note of the sorted run
      ST_PICK    // hand the found note to the result register
   } state_type;

   state_type            state_ff;
   req_code_type         op_ff;
   logic [NOTE_W-1:0]    note_ff;
   logic [VEL_W-1:0]     vel_ff;
   logic [VEL_W-1:0]     kept_vel_ff;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        held_ff;      // stored notes still carrying the held mark
   logic [MAX_W-1:0]     max_notes_ff;

   // scan pipeline around the store's registered read
   logic [CW-1:0]        rd_idx_ff;
   logic                 cmp_vld_ff;
   logic [AW-1:0]        cmp_idx_ff;
   logic [NOTE_W:0]      rd_data_ff;

   // sorted run emission
   logic [CW-1:0]        round_ff;
   logic [NOTE_W-1:0]    best_ff;
   logic [NOTE_W-1:0]    prev_ff;
   logic                 have_prev_ff;

   logic                 rsp_valid_ff;
   logic [NOTE_W-1:0]    rsp_note_ff;
   logic [SIZE_W-1:0]    rsp_size_ff;
   logic [VEL_W-1:0]     rsp_vel_ff;
   logic                 rsp_last_ff;

   // note store: bit 7 is the held mark, bits 6..0 the note
   logic [NOTE_W:0]      store_mem [CHORD_SLOTS];

   logic [LW-1:0]        lim_cap;
   logic                 at_limit;
   logic                 issue;
   logic                 scan_done;
   logic [NOTE_W-1:0]    rd_note;
   logic                 rd_held;
   logic                 hit;
   logic                 better;
   logic                 slot_free;
   logic                 run_last;
   logic                 csr_hit;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [NOTE_W:0]      wr_data;

   // limit is max_notes capped at the slot count
   assign lim_cap  = (LW'(max_notes_ff) > LW'(CHORD_SLOTS)) ? LW'(CHORD_SLOTS)
                                                             : LW'(max_notes_ff);
   assign at_limit = LW'(count_ff) >= lim_cap;

   assign issue     = rd_idx_ff != count_ff;
   assign scan_done = !issue && !cmp_vld_ff;
   assign rd_note   = rd_data_ff[NOTE_W-1:0];
   assign rd_held   = rd_data_ff[NOTE_W];
   assign hit       = cmp_vld_ff && (rd_note == note_ff);
   // next candidate: smallest note above the one sent last
   assign better    = cmp_vld_ff && (rd_note < best_ff) && (!have_prev_ff || rd_note > prev_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign run_last  = (round_ff + CW'(1)) == count_ff;

   assign csr_hit = csr_paddr[CSR_AW-1:2] == REG_MAX_NOTES;

   // store writes: release a held note on note off, append on a new note on
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cmp_idx_ff;
      wr_data = {1'b0, note_ff};
      if (state_ff == ST_MATCH) begin
         if (hit && op_ff == REQ_NOTE_OFF && rd_held) begin
            wr_en = 1'b1;
         end else if (scan_done && op_ff == REQ_NOTE_ON) begin
            wr_en   = 1'b1;
            wr_addr = count_ff[AW-1:0];
            wr_data = {1'b1, note_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         held_ff      <= '0;
         kept_vel_ff  <= '0;
         max_notes_ff <= MAX_NOTES_RESET;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
            max_notes_ff <= csr_pwdata[MAX_W-1:0];
         end

         // a new beat loaded in pick replaces the one taken
         if (rsp_valid_ff && rsp_ready && state_ff != ST_PICK) begin
            rsp_valid_ff <= 1'b0;
         end

         // one store entry read per cycle while scanning; the match scan
         // stops advancing once it leaves
         if ((state_ff == ST_MATCH && !hit && !scan_done) || state_ff == ST_MIN) begin
            cmp_vld_ff <= issue;
            cmp_idx_ff <= rd_idx_ff[AW-1:0];
            if (issue) begin
               rd_idx_ff <= rd_idx_ff + CW'(1);
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff      <= req_code_type'(req_type);
                  note_ff    <= req_note_number;
                  vel_ff     <= req_note_velocity;
                  rd_idx_ff  <= '0;
                  cmp_vld_ff <= 1'b0;
                  case (req_code_type'(req_type))
                     REQ_START: begin
                        count_ff <= '0;
                        held_ff  <= '0;
                     end
                     REQ_NOTE_ON: begin
                        if (!at_limit) begin
                           state_ff <= ST_MATCH;
                        end
                     end
                     REQ_NOTE_OFF: begin
                        if (count_ff != '0) begin
                           state_ff <= ST_MATCH;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end

            ST_MATCH: begin
               if (hit) begin
                  // a stored note: note on is a duplicate, note off releases it
                  if (op_ff == REQ_NOTE_ON) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     if (rd_held) begin
                        held_ff <= held_ff - CW'(1);
                     end
                     if (rd_held ? (held_ff == CW'(1)) : (held_ff == '0)) begin
                        state_ff     <= ST_MIN;
                        rd_idx_ff    <= '0;
                        cmp_vld_ff   <= 1'b0;
                        round_ff     <= '0;
                        have_prev_ff <= 1'b0;
                        best_ff      <= NOTE_TOP;
                     end else begin
                        state_ff <= ST_IDLE;
                     end
                  end
               end else if (scan_done) begin
                  if (op_ff == REQ_NOTE_ON) begin
                     count_ff    <= count_ff + CW'(1);
                     held_ff     <= held_ff + CW'(1);
                     kept_vel_ff <= vel_ff;
                     state_ff    <= ST_IDLE;
                  end else if (held_ff == '0) begin
                     state_ff     <= ST_MIN;
                     rd_idx_ff    <= '0;
                     cmp_vld_ff   <= 1'b0;
                     round_ff     <= '0;
                     have_prev_ff <= 1'b0;
                     best_ff      <= NOTE_TOP;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end

            ST_MIN: begin
               if (better) begin
                  best_ff <= rd_note;
               end
               if (scan_done) begin
                  state_ff <= ST_PICK;
               end
            end

            ST_PICK: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_note_ff  <= best_ff;
                  rsp_size_ff  <= SIZE_W'(count_ff);
                  rsp_vel_ff   <= kept_vel_ff;
                  rsp_last_ff  <= run_last;
                  if (run_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     prev_ff      <= best_ff;
                     have_prev_ff <= 1'b1;
                     best_ff      <= NOTE_TOP;
                     round_ff     <= round_ff + CW'(1);
                     rd_idx_ff    <= '0;
                     cmp_vld_ff   <= 1'b0;
                     state_ff     <= ST_MIN;
                  end
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready         = state_ff == ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chord_note    = rsp_note_ff;
   assign rsp_chord_size    = rsp_size_ff;
   assign rsp_last_velocity = rsp_vel_ff;
   assign rsp_is_last       = rsp_last_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DW'(max_notes_ff) : '0;

endmodule

// ===== rtl/mcc_checker.sv =====
module mcc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [mcc_pkg::REQ_W-1:0]  req_type,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [mcc_pkg::NOTE_W-1:0] rsp_chord_note,
   input logic [mcc_pkg::SIZE_W-1:0] rsp_chord_size,
   input logic                       rsp_is_last
);
   import mcc_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chord_note) && $stable(rsp_is_last))
      else $error("stalled result beat changed");

   // a chord always has at least one note
   a_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chord_size != '0)
      else $error("result beat with empty chord size");

   // no new request while a chord run is still unfinished
   a_busy_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_last |-> !req_ready)
      else $error("request taken in the middle of a chord run");

   // a start beat never produces a result
   a_start_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_START && !rsp_valid |=> !rsp_valid)
      else $error("result after a start beat");

endmodule

bind midi_chord_capture mcc_checker u_mcc_checker (.*);

// ===== bench/tb_top.sv =====
module tb_top;
   import mcc_pkg::*;

   // run limits, in clock cycles
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int DRAIN_CYCLES  = 50000;
   // enough for the slowest beat that makes no chord: a full serial scan plus slack
   localparam int SETTLE_CYCLES = 100;
   localparam int STORE_SLOTS   = 8;
   localparam int TOTAL_EVENTS  = 280;

   // one beat of a completed chord
   typedef struct packed {
      logic [NOTE_W-1:0] note;
      logic [SIZE_W-1:0] size;
      logic [VEL_W-1:0]  vel;
      logic              last;
   } chord_beat_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_code_type        req_type;
   logic [NOTE_W-1:0]   req_note_number;
   logic [VEL_W-1:0]    req_note_velocity;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [NOTE_W-1:0]   rsp_chord_note;
   logic [SIZE_W-1:0]   rsp_chord_size;
   logic [VEL_W-1:0]    rsp_last_velocity;
   logic                rsp_is_last;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // mirror of the block: note store (bit 7 = still held), count, kept velocity, limit
   logic [7:0]          note_store [STORE_SLOTS];
   int                  stored_count = 0;
   logic [VEL_W-1:0]    kept_vel = '0;
   logic [MAX_W-1:0]    max_notes_reg = MAX_NOTES_RESET;

   // chord beats predicted but not yet seen on the rsp_ side, oldest first
   chord_beat_type      chord_due_q [$];

   int                  errors = 0;
   int                  events_sent = 0;
   int                  cycle_count = 0;

   // idling controls for the req_ side and the rsp_ready driver
   bit                  req_gaps_on = 1'b1;
   bit                  rsp_stalls_on = 1'b1;
   bit                  rsp_hold_req = 1'b0;
   int                  rsp_hold_len = 0;

   midi_chord_capture i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_note_number   (req_note_number),
      .req_note_velocity (req_note_velocity),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_chord_note    (rsp_chord_note),
      .rsp_chord_size    (rsp_chord_size),
      .rsp_last_velocity (rsp_last_velocity),
      .rsp_is_last       (rsp_is_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // 8 time unit clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap(input bit enabled);
      int roll;
      if (!enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         errors++;
      end
   endfunction

   // chord capture mirror: update the store for one accepted beat and
   // queue the sorted chord when the last held note is released
   function automatic void capture_event(input req_code_type kind,
                                         input logic [NOTE_W-1:0] note,
                                         input logic [VEL_W-1:0] vel);
      int         lim;
      int         i;
      int         k;
      bit         found;
      bit         any_held;
      logic [7:0] moving;
      chord_beat_type beat;
      // limit is the register capped at the number of slots; zero takes nothing
      lim = (max_notes_reg > 4'd8) ? STORE_SLOTS : int'(max_notes_reg);
      found = 1'b0;
      any_held = 1'b0;
      case (kind)
         REQ_START: begin
            // velocity survives a clear
            stored_count = 0;
         end
         REQ_NOTE_ON: begin
            for (i = 0; i < stored_count; i++)
               if (note_store[i][6:0] == note) found = 1'b1;
            if (stored_count < lim && !found) begin
               note_store[stored_count] = {1'b1, note};
               stored_count++;
               kept_vel = vel;
            end
         end
         REQ_NOTE_OFF: begin
            // only the first match is released, even with a full store
            for (i = 0; i < stored_count; i++) begin
               if (!found && note_store[i][6:0] == note) begin
                  note_store[i] = {1'b0, note};
                  found = 1'b1;
               end
            end
            for (i = 0; i < stored_count; i++)
               if (note_store[i][7]) any_held = 1'b1;
            // all released: sort in place and emit, again on every later note off
            if (!any_held && stored_count != 0) begin
               for (i = 1; i < stored_count; i++) begin
                  moving = note_store[i];
                  k = i;
                  while (k > 0 && note_store[k-1] > moving) begin
                     note_store[k] = note_store[k-1];
                     k--;
                  end
                  note_store[k] = moving;
               end
               for (i = 0; i < stored_count; i++) begin
                  beat.note = note_store[i][6:0];
                  beat.size = SIZE_W'(stored_count);
                  beat.vel  = kept_vel;
                  beat.last = (i == stored_count - 1);
                  chord_due_q.push_back(beat);
               end
            end
         end
         default: begin
            // unused code: no effect
         end
      endcase
   endfunction

   // offer one beat on req_, hold it until taken, then predict
   task automatic send_event(input req_code_type kind, input logic [NOTE_W-1:0] note,
                             input logic [VEL_W-1:0] vel);
      int gap;
      gap = pick_gap(req_gaps_on);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid         = 1'b1;
      req_type          = kind;
      req_note_number   = note;
      req_note_velocity = vel;
      do @(posedge clock); while (!req_ready);
      capture_event(kind, note, vel);
      events_sent++;
   endtask

   // any code, any note, any velocity
   task automatic send_noise;
      send_event(req_code_type'($urandom_range(0, 3)), NOTE_W'($urandom_range(0, 127)),
                 VEL_W'($urandom_range(0, 127)));
   endtask

   // stop offering, let every predicted beat arrive, then let the block settle
   task automatic wait_idle;
      int guard;
      guard = 0;
      @(negedge clock);
      req_valid = 1'b0;
      while (chord_due_q.size() != 0 && guard < DRAIN_CYCLES) begin
         @(negedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one apb transfer: setup then access, completes when pready is high
   task automatic csr_cycle(input bit wr, input logic [CSR_DW-1:0] wdata,
                            output logic [CSR_DW-1:0] rdata);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = wr;
      csr_paddr   = {REG_MAX_NOTES, 2'b00};
      csr_pwdata  = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // write max_notes while idle (junk in the upper data bits), then read it back
   task automatic program_max_notes(input logic [MAX_W-1:0] value);
      logic [CSR_DW-1:0] wdata;
      logic [CSR_DW-1:0] rdata;
      wait_idle();
      wdata = $urandom;
      wdata[MAX_W-1:0] = value;
      csr_cycle(1'b1, wdata, rdata);
      max_notes_reg = value;
      csr_cycle(1'b0, '0, rdata);
      check_field("max_notes readback", int'(max_notes_reg), int'(rdata));
   endtask

   // one chord: usually a clear, then press, release in random order, sprinkled with noise
   task automatic play_chord(input int n);
      logic [NOTE_W-1:0] pressed [12];
      logic [NOTE_W-1:0] swap;
      int                i;
      int                j;
      if ($urandom_range(0, 9) != 0)
         send_event(REQ_START, NOTE_W'($urandom_range(0, 127)), VEL_W'($urandom_range(0, 127)));
      for (i = 0; i < n; i++) begin
         // a narrow window now and then so duplicates show up
         pressed[i] = ($urandom_range(0, 3) == 0) ? NOTE_W'($urandom_range(60, 67))
                                                  : NOTE_W'($urandom_range(0, 127));
         send_event(REQ_NOTE_ON, pressed[i], VEL_W'($urandom_range(0, 127)));
         if ($urandom_range(0, 11) == 0) send_noise();
      end
      for (i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap = pressed[i];
         pressed[i] = pressed[j];
         pressed[j] = swap;
      end
      for (i = 0; i < n; i++) begin
         send_event(REQ_NOTE_OFF, pressed[i], VEL_W'($urandom_range(0, 127)));
         if ($urandom_range(0, 11) == 0) send_noise();
      end
      // an extra release repeats the finished chord
      if (n > 0 && $urandom_range(0, 3) == 0)
         send_event(REQ_NOTE_OFF, pressed[$urandom_range(0, n - 1)], VEL_W'($urandom));
   endtask

   // mostly up to eight notes, sometimes more than the store can take
   function automatic int pick_chord_size;
      return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
   endfunction

   // randomly switch idling on either side, leaving stretches with none
   task automatic shuffle_idling;
      req_gaps_on   = ($urandom_range(0, 9) < 7);
      rsp_stalls_on = ($urandom_range(0, 9) < 7);
   endtask

   task automatic test_reset_value;
      logic [CSR_DW-1:0] rdata;
      csr_cycle(1'b0, '0, rdata);
      check_field("max_notes after reset", int'(MAX_NOTES_RESET), int'(rdata));
   endtask

   task automatic test_directed_events;
      // release with an empty store, then the unused code
      send_event(REQ_NOTE_OFF, 7'd60, 7'd10);
      send_event(REQ_UNUSED, NOTE_TOP, 7'd127);
      send_event(REQ_START, 7'd0, 7'd0);
      // extreme notes and velocities
      send_event(REQ_NOTE_ON, 7'd0, 7'd127);
      send_event(REQ_NOTE_ON, NOTE_TOP, 7'd0);
      send_event(REQ_NOTE_ON, 7'd64, 7'd5);
      // duplicate is dropped and keeps the old velocity
      send_event(REQ_NOTE_ON, 7'd64, 7'd99);
      // release of a note never stored, then of the two extreme notes
      send_event(REQ_NOTE_OFF, 7'd100, 7'd0);
      send_event(REQ_NOTE_OFF, NOTE_TOP, 7'd0);
      send_event(REQ_NOTE_OFF, 7'd0, 7'd0);
      // last release completes the chord, the next one repeats it
      send_event(REQ_NOTE_OFF, 7'd64, 7'd0);
      send_event(REQ_NOTE_OFF, 7'd64, 7'd127);
      // clear keeps the velocity; a new chord overrides it
      send_event(REQ_START, NOTE_TOP, 7'd127);
      send_event(REQ_NOTE_ON, 7'd42, 7'd85);
      send_event(REQ_NOTE_ON, 7'd21, 7'd42);
      send_event(REQ_NOTE_OFF, 7'd42, 7'd0);
      send_event(REQ_NOTE_OFF, 7'd21, 7'd0);
   endtask

   task automatic test_chord_limits;
      // limit of one: second note on is dropped, release still completes the full chord
      program_max_notes(4'd1);
      send_event(REQ_START, 7'd0, 7'd0);
      send_event(REQ_NOTE_ON, 7'd10, 7'd33);
      send_event(REQ_NOTE_ON, 7'd20, 7'd44);
      send_event(REQ_NOTE_OFF, 7'd20, 7'd0);
      send_event(REQ_NOTE_OFF, 7'd10, 7'd0);
      // limit of zero: nothing is stored, so no chord ever
      program_max_notes(4'd0);
      send_event(REQ_START, 7'd0, 7'd0);
      send_event(REQ_NOTE_ON, 7'd5, 7'd77);
      send_event(REQ_NOTE_OFF, 7'd5, 7'd0);
   endtask

   task automatic test_limit_sweep;
      logic [MAX_W-1:0] limits [5];
      int               i;
      int               phase_start;
      limits = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd5};
      for (i = 0; i < 5; i++) begin
         program_max_notes(limits[i]);
         phase_start = events_sent;
         while (events_sent - phase_start < 30) begin
            shuffle_idling();
            play_chord(pick_chord_size());
         end
      end
   endtask

   task automatic test_backpressure;
      int i;
      program_max_notes(4'd8);
      // receiver holds off for a long stretch while chords keep coming
      req_gaps_on  = 1'b0;
      rsp_hold_len = 400;
      rsp_hold_req = 1'b1;
      for (i = 0; i < 4; i++) play_chord(6);
   endtask

   task automatic test_random_chords;
      int chords;
      chords = 0;
      while (events_sent < TOTAL_EVENTS) begin
         // reprogram now and then, biased toward the full store
         if (chords % 6 == 5)
            program_max_notes(($urandom_range(0, 2) == 0) ? MAX_W'($urandom_range(0, 15))
                                                           : MAX_NOTES_RESET);
         shuffle_idling();
         play_chord(pick_chord_size());
         chords++;
      end
   endtask

   // rsp_ready driver: random stalls, plus a long hold-off counted here on request
   initial begin : rsp_ready_driver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            hold_left    = rsp_hold_len;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready  = 1'b1;
            stall_left = pick_gap(rsp_stalls_on);
         end
      end
   end

   // every accepted chord beat is matched against the oldest prediction
   always @(posedge clock) begin : chord_checker
      chord_beat_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (chord_due_q.size() == 0) begin
            $display("%0t: unexpected chord beat, actual note %0d size %0d", $time,
                     rsp_chord_note, rsp_chord_size);
            errors++;
         end else begin
            due = chord_due_q.pop_front();
            check_field("chord_note", int'(due.note), int'(rsp_chord_note));
            check_field("chord_size", int'(due.size), int'(rsp_chord_size));
            check_field("last_velocity", int'(due.vel), int'(rsp_last_velocity));
            check_field("is_last", int'(due.last), int'(rsp_is_last));
         end
      end
   end

   initial begin
      foreach (note_store[i]) note_store[i] = '0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_type          = REQ_START;
      req_note_number   = '0;
      req_note_velocity = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      test_reset_value();
      test_directed_events();
      test_chord_limits();
      test_limit_sweep();
      test_backpressure();
      test_random_chords();
      wait_idle();

      if (errors == 0 && chord_due_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mcc_pkg.sv
rtl/midi_chord_capture.sv
rtl/mcc_checker.sv
bench/tb_top.sv
